// ===== sv/mexp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the modular exponentiation core: word width, register indexes,
// the request type of the shared modular multiplier and its add-mod helper.
package mexp_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_W     = $clog2(WORD_BITS);
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_MODULUS  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_EXPONENT = CFG_ADDR_W'(1);

    localparam logic [WORD_BITS-1:0] MODULUS_RESET  = WORD_BITS'(2);
    localparam logic [WORD_BITS-1:0] EXPONENT_RESET = WORD_BITS'(1);

    typedef logic [WORD_BITS-1:0] word_t;

    // One request to the shared multiplier: result = a * b mod m.
    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
    } mul_req_t;

    typedef struct packed {
        logic  done;
        word_t result;
    } mul_rsp_t;

    // (x + y) mod m for x, y below m.
    function automatic word_t add_mod(input word_t x, input word_t y, input word_t m);
        logic [WORD_BITS:0] s;
        begin
            s = {1'b0, x} + {1'b0, y};
            if (s >= {1'b0, m}) begin
                s = s - {1'b0, m};
            end
            return s[WORD_BITS-1:0];
        end
    endfunction

endpackage

// ===== sv/mexp_mulmod.sv =====
`timescale 1ns / 1ps
// Iterative shift-and-add modular multiplier, one bit of b per cycle.
// Depends on mexp_pkg for the word width and the add_mod helper.
module mexp_mulmod import mexp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  word_t    modulus,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            acc_reg, acc_next;
    word_t            a_reg, a_next;
    word_t            b_reg, b_next;
    word_t            dbl;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        dbl       = add_mod(acc_reg, acc_reg, modulus);
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WORD_BITS - 1);
            acc_next  = '0;
            a_next    = req.a;
            b_next    = req.b;
        end else if (busy_reg) begin
            // Double, then add a when the current top bit of b is set.
            acc_next = b_reg[WORD_BITS-1] ? add_mod(dbl, a_reg, modulus) : dbl;
            b_next   = {b_reg[WORD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

// ===== sv/modular_exponentiation_core.sv =====
`timescale 1ns / 1ps
// Top level of the modular exponentiation core: configuration registers,
// square-and-multiply sequencer and output register. Uses mexp_pkg, mexp_mulmod.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    s_base_value, s_last_element
//   m_       out        m_valid/m_ready    m_power_result, m_last_out
//   cfg_     in         cfg_we (no wait)   cfg_addr, cfg_wdata
//
// Each request runs through one shared modular multiplier. A request costs
// one reduction of the base plus one squaring per exponent bit and one
// multiply per set exponent bit. A zero exponent or a modulus below two
// goes straight to the final state without the multiplier. Reset is
// synchronous and active low and sets the modulus to 2 and the exponent to
// 1. The output register holds a finished result while m_ready is low; a new
// request may be accepted meanwhile, and the sequencer waits in its final
// state if the next result finds the register still occupied.
module modular_exponentiation_core import mexp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [WORD_BITS-1:0]  cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [WORD_BITS-1:0]  s_base_value,
    input  logic                  s_last_element,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [WORD_BITS-1:0]  m_power_result,
    output logic                  m_last_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    word_t            modulus_reg, exponent_reg;
    word_t            base_reg, base_next;
    word_t            acc_reg, acc_next;
    logic             last_reg, last_next;
    logic [CNT_W-1:0] bit_reg, bit_next;
    logic             m_valid_reg, m_valid_next;
    word_t            result_reg, result_next;
    logic             last_out_reg, last_out_next;
    mul_req_t         mul_req;
    mul_rsp_t         mul_rsp;
    logic             accept;

    // The user keeps configuration writes to idle; the core does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= MODULUS_RESET;
            exponent_reg <= EXPONENT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MODULUS:  modulus_reg  <= cfg_wdata;
                REG_EXPONENT: exponent_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    mexp_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .modulus (modulus_reg),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next    = state_reg;
        base_next     = base_reg;
        acc_next      = acc_reg;
        last_next     = last_reg;
        bit_next      = bit_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        result_next   = result_reg;
        last_out_next = last_out_reg;
        mul_req       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    last_next = s_last_element;
                    if (exponent_reg == '0) begin
                        acc_next   = WORD_BITS'(1);
                        state_next = ST_FINISH;
                    end else if (modulus_reg[WORD_BITS-1:1] == '0) begin
                        acc_next   = '0;
                        state_next = ST_FINISH;
                    end else begin
                        // The base is reduced as 1 * base mod modulus.
                        mul_req.start = 1'b1;
                        mul_req.a     = WORD_BITS'(1);
                        mul_req.b     = s_base_value;
                        state_next    = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (mul_rsp.done) begin
                    base_next     = mul_rsp.result;
                    bit_next      = CNT_W'(WORD_BITS - 1);
                    mul_req.start = 1'b1;
                    mul_req.a     = WORD_BITS'(1);
                    mul_req.b     = WORD_BITS'(1);
                    state_next    = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (mul_rsp.done) begin
                    acc_next = mul_rsp.result;
                    if (exponent_reg[bit_reg]) begin
                        mul_req.start = 1'b1;
                        mul_req.a     = mul_rsp.result;
                        mul_req.b     = base_reg;
                        state_next    = ST_MULT;
                    end else if (bit_reg == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        bit_next      = bit_reg - 1'b1;
                        mul_req.start = 1'b1;
                        mul_req.a     = mul_rsp.result;
                        mul_req.b     = mul_rsp.result;
                    end
                end
            end
            ST_MULT: begin
                if (mul_rsp.done) begin
                    acc_next = mul_rsp.result;
                    if (bit_reg == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        bit_next      = bit_reg - 1'b1;
                        mul_req.start = 1'b1;
                        mul_req.a     = mul_rsp.result;
                        mul_req.b     = mul_rsp.result;
                        state_next    = ST_SQUARE;
                    end
                end
            end
            ST_FINISH: begin
                // Hand the result over once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    result_next   = acc_reg;
                    last_out_next = last_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            bit_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            bit_reg     <= bit_next;
        end
        base_reg     <= base_next;
        acc_reg      <= acc_next;
        last_reg     <= last_next;
        result_reg   <= result_next;
        last_out_reg <= last_out_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_power_result = result_reg;
    assign m_last_out     = last_out_reg;

endmodule

// ===== sv/mexp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for modular_exponentiation_core, bound to the top level.
// Depends on mexp_pkg for the word width.
module mexp_checker import mexp_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [WORD_BITS-1:0]  m_power_result,
    input logic                  m_last_out
);

    // The core works on one request at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("core ready again right after accepting a request");

    // No result can appear in the cycle right after a request is taken.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result appeared too early");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_power_result)
                                   && $stable(m_last_out)))
        else $error("stalled result changed or dropped");

    // Reset leaves the output channel empty.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_power_result (m_power_result),
    .m_last_out     (m_last_out)
);
